### rtl/core/oamr_pkg.sv
// Shared types, codes and command structs for the operand address mode resolver.
package oamr_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [15:0] data;
    logic [5:0]  specifier;
  } oamr_in_t;

  typedef struct packed {
    logic [15:0] operand_address;
    logic [15:0] operand_value;
    logic        is_register;
    logic        mode_error;
  } oamr_out_t;

  localparam logic [1:0] ITEM_MEM_WR  = 2'd0;
  localparam logic [1:0] ITEM_REG_WR  = 2'd1;
  localparam logic [1:0] ITEM_RESOLVE = 2'd2;

  localparam logic [2:0] AM_REG         = 3'd0;
  localparam logic [2:0] AM_DEF         = 3'd1;
  localparam logic [2:0] AM_AUTOINC     = 3'd2;
  localparam logic [2:0] AM_AUTOINC_DEF = 3'd3;
  localparam logic [2:0] AM_AUTODEC     = 3'd4;
  localparam logic [2:0] AM_AUTODEC_DEF = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REM,
    ST_WRITE,
    ST_READ,
    ST_FETCH
  } oamr_state_t;

  typedef enum logic [1:0] {
    XS_ADDR,
    XS_REG,
    XS_REG_DEC,
    XS_RDATA
  } oamr_xsel_t;

  typedef enum logic [1:0] {
    REG_NONE,
    REG_WRITE,
    REG_INC,
    REG_DEC
  } oamr_regop_t;

  typedef enum logic [2:0] {
    EA_HOLD,
    EA_REGNUM,
    EA_REG,
    EA_REG_DEC,
    EA_RDATA,
    EA_ZERO
  } oamr_easel_t;

  typedef enum logic [1:0] {
    VAL_HOLD,
    VAL_REG,
    VAL_RDATA,
    VAL_ZERO
  } oamr_valsel_t;

  typedef struct packed {
    logic         capture;
    oamr_xsel_t   x_sel;
    logic         ld_q;
    logic         ld_idx;
    logic         mem_we;
    logic         mem_re;
    oamr_regop_t  reg_op;
    oamr_easel_t  ea_sel;
    oamr_valsel_t val_sel;
    logic         is_reg;
    logic         err;
    logic         finish;
  } oamr_cmd_t;

  typedef struct packed {
    logic [1:0] item_mode;
    logic [2:0] addr_mode;
  } oamr_sts_t;

endpackage

### rtl/core/oamr_ram.sv
// Generic single-port RAM with registered read.
module oamr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/oamr_ctrl.sv
// Sequencer for operand resolution, memory writes and register writes.
module oamr_ctrl import oamr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  oamr_sts_t sts,
  output oamr_cmd_t cmd,
  output logic      busy
);

  oamr_state_t state_r, state_nxt;
  logic        second_r, second_nxt;
  logic        deferred;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  assign deferred = (sts.addr_mode == AM_AUTOINC_DEF) || (sts.addr_mode == AM_AUTODEC_DEF);
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        second_nxt = 1'b0;
        case (sts.item_mode)
          ITEM_MEM_WR: begin
            cmd.x_sel = XS_ADDR;
            cmd.ld_q  = 1'b1;
            state_nxt = ST_REM;
          end
          ITEM_REG_WR: begin
            cmd.reg_op = REG_WRITE;
            state_nxt  = ST_IDLE;
          end
          ITEM_RESOLVE: begin
            case (sts.addr_mode)
              AM_REG: begin
                cmd.ea_sel  = EA_REGNUM;
                cmd.val_sel = VAL_REG;
                cmd.is_reg  = 1'b1;
                cmd.finish  = 1'b1;
                state_nxt   = ST_IDLE;
              end
              AM_DEF, AM_AUTOINC: begin
                cmd.x_sel  = XS_REG;
                cmd.ld_q   = 1'b1;
                cmd.ea_sel = EA_REG;
                cmd.reg_op = (sts.addr_mode == AM_AUTOINC) ? REG_INC : REG_NONE;
                state_nxt  = ST_REM;
              end
              AM_AUTOINC_DEF: begin
                cmd.x_sel  = XS_REG;
                cmd.ld_q   = 1'b1;
                cmd.reg_op = REG_INC;
                state_nxt  = ST_REM;
              end
              AM_AUTODEC: begin
                cmd.x_sel  = XS_REG_DEC;
                cmd.ld_q   = 1'b1;
                cmd.ea_sel = EA_REG_DEC;
                cmd.reg_op = REG_DEC;
                state_nxt  = ST_REM;
              end
              AM_AUTODEC_DEF: begin
                cmd.x_sel  = XS_REG_DEC;
                cmd.ld_q   = 1'b1;
                cmd.reg_op = REG_DEC;
                state_nxt  = ST_REM;
              end
              default: begin
                cmd.ea_sel  = EA_ZERO;
                cmd.val_sel = VAL_ZERO;
                cmd.err     = 1'b1;
                cmd.finish  = 1'b1;
                state_nxt   = ST_IDLE;
              end
            endcase
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_REM: begin
        cmd.ld_idx = 1'b1;
        state_nxt  = (sts.item_mode == ITEM_MEM_WR) ? ST_WRITE : ST_READ;
      end
      ST_WRITE: begin
        cmd.mem_we = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_READ: begin
        cmd.mem_re = 1'b1;
        state_nxt  = ST_FETCH;
      end
      ST_FETCH: begin
        if (deferred && !second_r) begin
          cmd.ea_sel = EA_RDATA;
          cmd.x_sel  = XS_RDATA;
          cmd.ld_q   = 1'b1;
          second_nxt = 1'b1;
          state_nxt  = ST_REM;
        end else begin
          cmd.val_sel = VAL_RDATA;
          cmd.finish  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/oamr_dp.sv
// Datapath: item capture, register file, word index reduction, word memory and result register.
module oamr_dp import oamr_pkg::*; #(
  parameter int MEM_WORDS = 32768,
  localparam int AW = $clog2(MEM_WORDS)
) (
  input  logic      clk,
  input  logic      rst_n,
  input  oamr_in_t  in_item,
  input  oamr_cmd_t cmd,
  output oamr_sts_t sts,
  output logic      out_strobe,
  output oamr_out_t out_item
);

  localparam int K     = 30;
  localparam int RECIP = (2 ** K) / MEM_WORDS;
  localparam int RW    = 31 - AW;
  localparam int QW    = 16 - AW;
  localparam int PW    = 15 + RW;
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
  localparam logic [15:0]   MW      = 16'(MEM_WORDS);

  oamr_in_t    item_r;
  logic [15:0] regs_r [8];
  logic [14:0] x_r;
  logic [QW-1:0] q_r;
  logic [AW-1:0] idx_r;
  logic [15:0] ea_r;
  logic        out_strobe_r;
  oamr_out_t   out_item_r;

  logic [2:0]  r_sel;
  logic [15:0] reg_val, reg_inc, reg_dec, rdata;
  logic [15:0] x_src;
  logic [14:0] x_nxt;
  logic [PW-1:0] prod;
  logic [15:0] mq, rem, rem_fix;
  logic [15:0] ea_d, val_d;

  assign r_sel   = item_r.specifier[2:0];
  assign reg_val = regs_r[r_sel];
  assign reg_inc = reg_val + 16'd2;
  assign reg_dec = reg_val - 16'd2;

  assign sts.item_mode = item_r.mode;
  assign sts.addr_mode = item_r.specifier[5:3];

  always_comb begin
    case (cmd.x_sel)
      XS_ADDR:    x_src = item_r.address;
      XS_REG:     x_src = reg_val;
      XS_REG_DEC: x_src = reg_dec;
      XS_RDATA:   x_src = rdata;
      default:    x_src = item_r.address;
    endcase
  end

  assign x_nxt   = x_src[15:1];
  assign prod    = PW'(x_nxt) * PW'(RECIP_V);
  assign mq      = 16'(16'(q_r) * MW);
  assign rem     = {1'b0, x_r} - mq;
  assign rem_fix = (rem >= MW) ? (rem - MW) : rem;

  always_comb begin
    case (cmd.ea_sel)
      EA_HOLD:    ea_d = ea_r;
      EA_REGNUM:  ea_d = {13'd0, r_sel};
      EA_REG:     ea_d = reg_val;
      EA_REG_DEC: ea_d = reg_dec;
      EA_RDATA:   ea_d = rdata;
      EA_ZERO:    ea_d = 16'd0;
      default:    ea_d = ea_r;
    endcase
  end

  always_comb begin
    case (cmd.val_sel)
      VAL_REG:   val_d = reg_val;
      VAL_RDATA: val_d = rdata;
      VAL_ZERO:  val_d = 16'd0;
      default:   val_d = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= 16'd0;
      end
      out_strobe_r <= 1'b0;
    end else begin
      case (cmd.reg_op)
        REG_WRITE: regs_r[item_r.address[2:0]] <= item_r.data;
        REG_INC:   regs_r[r_sel] <= reg_inc;
        REG_DEC:   regs_r[r_sel] <= reg_dec;
        default:   ;
      endcase
      out_strobe_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.ld_q) begin
      x_r <= x_nxt;
      q_r <= prod[K +: QW];
    end
    if (cmd.ld_idx) begin
      idx_r <= rem_fix[AW-1:0];
    end
    ea_r <= ea_d;
    if (cmd.finish) begin
      out_item_r.operand_address <= ea_d;
      out_item_r.operand_value   <= val_d;
      out_item_r.is_register     <= cmd.is_reg;
      out_item_r.mode_error      <= cmd.err;
    end
  end

  oamr_ram #(
    .WIDTH (16),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.mem_we),
    .re    (cmd.mem_re),
    .addr  (idx_r),
    .wdata (item_r.data),
    .rdata (rdata)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

### rtl/core/operand_address_mode_resolver.sv
// Top level of the operand address mode resolver.
//
//   channel   ports                    beat taken when
//   input     start, busy, in_item     start high and busy low at the clock edge
//   result    out_strobe, out_item     out_strobe high (one cycle, no back-pressure)
//
// Register writes, register operands and mode 6/7 errors need no memory access. A
// memory write walks index multiply, index remainder and write; a read walks index
// multiply, index remainder, read and data return on the single word memory port,
// twice for deferred autoincrement and autodecrement. The result shows in the cycle
// after the last step. Reset (rst_n low, synchronous) clears the register file and
// the sequencer; memory contents stay undefined. Results are never held off.
module operand_address_mode_resolver import oamr_pkg::*; #(
  parameter int MEM_WORDS = 32768
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  oamr_in_t  in_item,
  output logic      out_strobe,
  output oamr_out_t out_item
);

  oamr_cmd_t cmd;
  oamr_sts_t sts;

  oamr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  oamr_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

### rtl/core/oamr_chk.sv
// Port-level checker for the operand address mode resolver and its bind.
module oamr_chk import oamr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input oamr_out_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without preceding work");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result beats back to back");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.mode_error) |->
      (out_item.operand_address == 16'd0) && (out_item.operand_value == 16'd0) &&
      !out_item.is_register)
    else $error("mode error beat carries data");

  a_register_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.is_register) |->
      (out_item.operand_address[15:3] == 13'd0) && !out_item.mode_error)
    else $error("register operand beat malformed");

endmodule

bind operand_address_mode_resolver oamr_chk u_oamr_chk (.*);

### bench/operand_address_mode_resolver_test.sv
// Self-checking testbench for the operand address mode resolver.
module operand_address_mode_resolver_test import oamr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_WORDS = 32768;
  localparam int ITEM_TARGET = 1300;
  localparam logic [1:0] ITEM_IGNORED = 2'd3;
  localparam logic [2:0] AM_UNDEF_6 = 3'd6;
  localparam logic [2:0] AM_UNDEF_7 = 3'd7;
  localparam logic [15:0] STEP = 16'd2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  oamr_in_t in_item = '0;
  logic out_strobe;
  oamr_out_t out_item;

  logic [15:0] regs [8];
  logic [15:0] mem_words [int];
  int filled_words [$];
  oamr_in_t pending_items [$];
  oamr_out_t expected_results [$];
  bit holding = 1'b0;
  int idle_pct = 0;
  int idle_by_phase [4] = '{0, 68, 20, 0};
  int beats_taken = 0;
  int fail_count = 0;
  int resolves_by_am [8];
  int mem_writes = 0;
  int reg_writes = 0;
  int ignored_beats = 0;
  event beat_taken;

  operand_address_mode_resolver #(.MEM_WORDS(MEM_WORDS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int word_of(logic [15:0] byte_addr);
    return (int'(byte_addr) >> 1) % MEM_WORDS;
  endfunction

  function automatic logic [15:0] read_word(logic [15:0] byte_addr);
    if (mem_words.exists(word_of(byte_addr))) return mem_words[word_of(byte_addr)];
    return 16'h0000;
  endfunction

  task automatic apply_beat(input oamr_in_t beat);
    logic [2:0] am;
    logic [2:0] r;
    oamr_out_t res;
    am = beat.specifier[5:3];
    r = beat.specifier[2:0];
    res = '0;
    case (beat.mode)
      ITEM_MEM_WR: begin
        if (!mem_words.exists(word_of(beat.address))) filled_words.push_back(word_of(beat.address));
        mem_words[word_of(beat.address)] = beat.data;
        mem_writes++;
      end
      ITEM_REG_WR: begin
        regs[beat.address[2:0]] = beat.data;
        reg_writes++;
      end
      ITEM_RESOLVE: begin
        case (am)
          AM_REG: begin
            res.operand_address = {13'd0, r};
            res.operand_value = regs[r];
            res.is_register = 1'b1;
          end
          AM_DEF: begin
            res.operand_address = regs[r];
            res.operand_value = read_word(res.operand_address);
          end
          AM_AUTOINC: begin
            res.operand_address = regs[r];
            res.operand_value = read_word(res.operand_address);
            regs[r] = regs[r] + STEP;
          end
          AM_AUTOINC_DEF: begin
            res.operand_address = read_word(regs[r]);
            regs[r] = regs[r] + STEP;
            res.operand_value = read_word(res.operand_address);
          end
          AM_AUTODEC: begin
            regs[r] = regs[r] - STEP;
            res.operand_address = regs[r];
            res.operand_value = read_word(res.operand_address);
          end
          AM_AUTODEC_DEF: begin
            regs[r] = regs[r] - STEP;
            res.operand_address = read_word(regs[r]);
            res.operand_value = read_word(res.operand_address);
          end
          default: begin
            res.mode_error = 1'b1;
          end
        endcase
        expected_results.push_back(res);
        resolves_by_am[am]++;
      end
      default: begin
        ignored_beats++;
      end
    endcase
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    if (fail_count < 40) begin
      $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    end
    fail_count++;
  endtask

  // Drive on the falling edge; hold the beat until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!holding) begin
      if (pending_items.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
        holding = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    oamr_out_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", out_item.operand_address, 16'h0000);
      end else begin
        want = expected_results.pop_front();
        if (out_item.operand_address !== want.operand_address)
          report_mismatch("operand_address", out_item.operand_address, want.operand_address);
        if (out_item.operand_value !== want.operand_value)
          report_mismatch("operand_value", out_item.operand_value, want.operand_value);
        if (out_item.is_register !== want.is_register)
          report_mismatch("is_register", 16'(out_item.is_register), 16'(want.is_register));
        if (out_item.mode_error !== want.mode_error)
          report_mismatch("mode_error", 16'(out_item.mode_error), 16'(want.mode_error));
      end
    end
    if (rst_n && start && !busy) begin
      apply_beat(in_item);
      if (in_item.mode != ITEM_IGNORED) beats_taken++;
      holding = 1'b0;
      -> beat_taken;
    end
  end

  function automatic oamr_in_t make_beat(logic [1:0] kind, logic [15:0] a, logic [15:0] d,
                                         logic [5:0] s);
    oamr_in_t b;
    b.mode = kind;
    b.address = a;
    b.data = d;
    b.specifier = s;
    return b;
  endfunction

  task automatic send(input oamr_in_t beat);
    pending_items.push_back(beat);
    @(beat_taken);
  endtask

  task automatic write_mem(input logic [15:0] a, input logic [15:0] d);
    send(make_beat(ITEM_MEM_WR, a, d, 6'($urandom)));
  endtask

  task automatic write_reg(input logic [15:0] a, input logic [15:0] d);
    send(make_beat(ITEM_REG_WR, a, d, 6'($urandom)));
  endtask

  // Find a memory word the specifier would read before it was ever written.
  function automatic bit needs_fill(input logic [5:0] spec, output logic [15:0] fill_addr);
    logic [2:0] am;
    logic [15:0] p;
    am = spec[5:3];
    fill_addr = '0;
    case (am)
      AM_DEF, AM_AUTOINC, AM_AUTOINC_DEF: p = regs[spec[2:0]];
      AM_AUTODEC, AM_AUTODEC_DEF: p = regs[spec[2:0]] - STEP;
      default: return 1'b0;
    endcase
    if (!mem_words.exists(word_of(p))) begin
      fill_addr = p;
      return 1'b1;
    end
    if (am == AM_AUTOINC_DEF || am == AM_AUTODEC_DEF) begin
      p = mem_words[word_of(p)];
      if (!mem_words.exists(word_of(p))) begin
        fill_addr = p;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic resolve(input logic [5:0] spec);
    logic [15:0] fill_addr;
    while (needs_fill(spec, fill_addr)) write_mem(fill_addr, 16'($urandom));
    send(make_beat(ITEM_RESOLVE, 16'($urandom), 16'($urandom), spec));
  endtask

  function automatic logic [15:0] pick_filled_addr();
    if (filled_words.size() == 0) return 16'($urandom);
    return 16'(filled_words[$urandom_range(filled_words.size() - 1, 0)] * 2)
           | 16'($urandom_range(1, 0));
  endfunction

  task automatic wait_results_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [2:0] am;
    logic [2:0] r;
    logic [15:0] a;
    int sel;
    foreach (regs[i]) regs[i] = 16'h0000;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    resolve({AM_REG, 3'd0});
    write_reg(16'hFFFF, 16'hFFFF);
    resolve({AM_REG, 3'd7});
    write_mem(16'hFFFF, 16'h0000);
    write_mem(16'h0000, 16'hFFFE);
    resolve({AM_DEF, 3'd7});
    resolve({AM_AUTOINC, 3'd7});
    resolve({AM_DEF, 3'd7});
    resolve({AM_AUTODEC, 3'd7});
    resolve({AM_AUTOINC_DEF, 3'd7});
    resolve({AM_AUTODEC_DEF, 3'd7});
    write_reg(16'h0008, 16'h8000);
    write_mem(16'h8001, 16'h1234);
    resolve({AM_DEF, 3'd0});
    resolve({AM_UNDEF_6, 3'd3});
    resolve({AM_UNDEF_7, 3'd7});
    send(make_beat(ITEM_IGNORED, 16'hFFFF, 16'hFFFF, 6'h3F));
    resolve({AM_REG, 3'd0});
    resolve({AM_REG, 3'd3});

    for (int ph = 0; ph < 4; ph++) begin
      wait_results_drained();
      repeat (4) @(posedge clk);
      idle_pct = idle_by_phase[ph];
      while (beats_taken < (ph + 1) * ITEM_TARGET / 4) begin
        sel = $urandom_range(99, 0);
        r = 3'($urandom_range(7, 0));
        if (sel < 40) begin
          resolve({3'($urandom_range(7, 0)), r});
        end else if (sel < 56) begin
          am = 3'($urandom_range(AM_AUTODEC_DEF, AM_AUTOINC));
          repeat ($urandom_range(6, 2)) resolve({am, r});
        end else if (sel < 70) begin
          a = 16'($urandom);
          a[2:0] = r;
          write_reg(a, $urandom_range(2, 0) != 0 ? pick_filled_addr() : 16'($urandom));
        end else if (sel < 82) begin
          write_mem(16'($urandom),
                    $urandom_range(1, 0) != 0 ? pick_filled_addr() : 16'($urandom));
        end else if (sel < 96) begin
          a = regs[r] - ($urandom_range(1, 0) != 0 ? STEP : 16'h0000);
          write_mem(a ^ 16'($urandom_range(1, 0)),
                    $urandom_range(1, 0) != 0 ? pick_filled_addr() : 16'($urandom));
        end else begin
          send(make_beat(ITEM_IGNORED, 16'($urandom), 16'($urandom), 6'($urandom)));
        end
      end
    end

    wait_results_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d beats: %0d memory writes, %0d register writes, %0d ignored",
             beats_taken, mem_writes, reg_writes, ignored_beats);
    $display("resolves per addressing mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             resolves_by_am[0], resolves_by_am[1], resolves_by_am[2], resolves_by_am[3],
             resolves_by_am[4], resolves_by_am[5], resolves_by_am[6], resolves_by_am[7]);
    if (fail_count == 0) begin
      $display("** operand_address_mode_resolver: PASSED **");
    end else begin
      $display("** operand_address_mode_resolver: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("** operand_address_mode_resolver: FAILED **");
    $finish;
  end

endmodule
